// ===== sv/gws_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gws_pkg
// Shared types and codes for the grid word search unit.
// ============================================================================
package gws_pkg;

    // Action codes of an input item
    localparam logic [1:0] ACT_GRID   = 2'd0;
    localparam logic [1:0] ACT_WORD   = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    // Search directions, in the order they are tried
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_MATCH = 2'd0;
    localparam logic [1:0] STAT_NONE  = 2'd1;
    localparam logic [1:0] STAT_SHORT = 2'd2;

    // Configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // Width of word length and letter counters, and of bound sums
    localparam int LEN_W = 7;
    localparam int BND_W = 8;

    typedef struct packed {
        logic [1:0] action;
        logic [5:0] row;
        logic [3:0] col;
        logic [7:0] letter;
        logic [3:0] letter_index;
        logic       final_letter;
    } t_in_item;

    typedef struct packed {
        logic [5:0] start_row;
        logic [3:0] start_col;
        logic [1:0] direction;
        logic [1:0] status;
        logic       last;
    } t_out_item;

    // Clamped settings handed to the sequencer
    typedef struct packed {
        logic [6:0]       rows;
        logic [4:0]       cols;
        logic [LEN_W-1:0] len;
    } t_cfg;

endpackage

// ===== sv/gws_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gws_ram
// Single write port, single read port memory with registered read data.
// ============================================================================
module gws_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== sv/gws_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gws_ctrl
// Search sequencer: walks candidates, compares letters, stages results.
// ============================================================================
module gws_ctrl #(
    parameter int MAX_COLS = 16,
    parameter int GAW      = 10,
    parameter int WA       = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gws_pkg::t_in_item   i_in_item,
    input  gws_pkg::t_cfg       i_cfg,
    output logic [GAW-1:0]      o_grid_raddr,
    input  logic [7:0]          i_grid_q,
    output logic [WA-1:0]       o_word_raddr,
    input  logic [7:0]          i_word_q,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gws_pkg::t_out_item  o_out_item
);
    import gws_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_PUSH  = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [5:0]       r_row, n_row;
    logic [3:0]       r_col, n_col;
    logic [1:0]       r_dir, n_dir;
    logic [GAW-1:0]   r_addr, n_addr;
    logic [GAW-1:0]   r_step, n_step;
    logic [LEN_W-1:0] r_widx, n_widx;
    logic             r_cmp_v, n_cmp_v;
    logic             r_cmp_end, n_cmp_end;
    logic             r_pend_v, n_pend_v;
    logic [3:0]       r_pend_col, n_pend_col;
    logic [1:0]       r_pend_dir, n_pend_dir;
    logic             r_short, n_short;
    logic             r_out_v, n_out_v;
    t_out_item        r_out, n_out;

    logic             w_slot;
    logic             w_last_cand;
    logic [2:0]       w_adv_state;
    logic [3:0]       w_adv_col;
    logic [1:0]       w_adv_dir;
    logic             w_fit_ok;
    logic [GAW-1:0]   w_step;
    logic             w_mismatch;
    logic [BND_W-1:0] w_len_b;

    assign w_slot      = !r_out_v || i_out_ready;
    assign w_mismatch  = r_cmp_v && (i_grid_q != i_word_q);
    assign w_len_b     = BND_W'(i_cfg.len);
    assign w_last_cand = (r_dir == DIR_RIGHT) && ({1'b0, r_col} == i_cfg.cols - 5'd1);

    // Next candidate: next direction, or first direction of next column; after the last one, the final state
    always_comb begin
        w_adv_state = S_START;
        w_adv_col   = r_col;
        w_adv_dir   = r_dir + 2'd1;
        if (w_last_cand) begin
            w_adv_state = S_FINAL;
        end else if (r_dir == DIR_RIGHT) begin
            w_adv_col = r_col + 4'd1;
        end
    end

    // The whole word lies inside the grid if its far end does
    always_comb begin
        case (r_dir)
            DIR_UP: begin
                w_fit_ok = BND_W'(r_row) + BND_W'(1) >= w_len_b;
                w_step   = GAW'(-MAX_COLS);
            end
            DIR_LEFT: begin
                w_fit_ok = BND_W'(r_col) + BND_W'(1) >= w_len_b;
                w_step   = '1;
            end
            DIR_DOWN: begin
                w_fit_ok = BND_W'(r_row) + w_len_b <= BND_W'(i_cfg.rows);
                w_step   = GAW'(MAX_COLS);
            end
            default: begin
                w_fit_ok = BND_W'(r_col) + w_len_b <= BND_W'(i_cfg.cols);
                w_step   = GAW'(1);
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_dir      = r_dir;
        n_addr     = r_addr;
        n_step     = r_step;
        n_widx     = r_widx;
        n_cmp_v    = r_cmp_v;
        n_cmp_end  = r_cmp_end;
        n_pend_v   = r_pend_v;
        n_pend_col = r_pend_col;
        n_pend_dir = r_pend_dir;
        n_short    = r_short;
        n_out_v    = r_out_v;
        n_out      = r_out;

        if (r_out_v && i_out_ready) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_item.action == ACT_SEARCH) begin
                    n_row    = i_in_item.row;
                    n_col    = '0;
                    n_dir    = DIR_UP;
                    n_pend_v = 1'b0;
                    n_short  = i_cfg.len < LEN_W'(2);
                    if (i_cfg.len < LEN_W'(2) || {1'b0, i_in_item.row} >= i_cfg.rows) begin
                        n_state = S_FINAL;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_cmp_v = 1'b0;
                n_widx  = '0;
                n_addr  = GAW'(32'(r_row) * MAX_COLS + 32'(r_col));
                n_step  = w_step;
                if (w_fit_ok) begin
                    n_state = S_WALK;
                end else begin
                    n_state = w_adv_state;
                    n_col   = w_adv_col;
                    n_dir   = w_adv_dir;
                end
            end
            S_WALK: begin
                if (w_mismatch) begin
                    n_state = w_adv_state;
                    n_col   = w_adv_col;
                    n_dir   = w_adv_dir;
                end else if (r_cmp_v && r_cmp_end) begin
                    n_state = S_PUSH;
                end else if (r_widx < i_cfg.len) begin
                    n_addr    = r_addr + r_step;
                    n_widx    = r_widx + LEN_W'(1);
                    n_cmp_v   = 1'b1;
                    n_cmp_end = r_widx == i_cfg.len - LEN_W'(1);
                end else begin
                    n_cmp_v = 1'b0;
                end
            end
            S_PUSH: begin
                // Hold the newest match back until it is known whether it is the last
                if (!r_pend_v || w_slot) begin
                    if (r_pend_v) begin
                        n_out_v           = 1'b1;
                        n_out.start_row   = r_row;
                        n_out.start_col   = r_pend_col;
                        n_out.direction   = r_pend_dir;
                        n_out.status      = STAT_MATCH;
                        n_out.last        = 1'b0;
                    end
                    n_pend_v   = 1'b1;
                    n_pend_col = r_col;
                    n_pend_dir = r_dir;
                    n_state    = w_adv_state;
                    n_col      = w_adv_col;
                    n_dir      = w_adv_dir;
                end
            end
            S_FINAL: begin
                if (w_slot) begin
                    n_out_v         = 1'b1;
                    n_out.start_row = r_row;
                    n_out.last      = 1'b1;
                    if (r_pend_v) begin
                        n_out.start_col = r_pend_col;
                        n_out.direction = r_pend_dir;
                        n_out.status    = STAT_MATCH;
                    end else begin
                        n_out.start_col = '0;
                        n_out.direction = DIR_UP;
                        n_out.status    = r_short ? STAT_SHORT : STAT_NONE;
                    end
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cmp_v  <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cmp_v  <= n_cmp_v;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_col      <= n_col;
        r_dir      <= n_dir;
        r_addr     <= n_addr;
        r_step     <= n_step;
        r_widx     <= n_widx;
        r_cmp_end  <= n_cmp_end;
        r_pend_col <= n_pend_col;
        r_pend_dir <= n_pend_dir;
        r_short    <= n_short;
        r_out      <= n_out;
    end

    assign o_in_ready   = r_state == S_IDLE;
    assign o_grid_raddr = r_addr;
    assign o_word_raddr = r_widx[WA-1:0];
    assign o_out_valid  = r_out_v;
    assign o_out_item   = r_out;

endmodule

// ===== sv/grid_word_search_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// grid_word_search_unit
// Four-direction word search over a stored character grid.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries items of three kinds:
//   grid cell writes, word letter writes and row searches. Writes give no
//   result. A search walks every column of the named row,
//   trying up, left, down and right, and emits one result item per match on
//   the output channel (o_out_valid / i_out_ready), the final one with last
//   set. An empty row gives one no-match item, a word under two letters one
//   error item.
//   Timing: each candidate first gets a bound check; a candidate that fits
//   then walks the word, one grid read and one letter compare per cycle
//   through the shared compare unit, and a match is then staged. The letter
//   walk over the single grid read port sets the length of a search.
//   The input is not ready while a search runs.
//   The output register parts the two sides: a new item is taken while the
//   last result still waits. A stalled receiver holds the search at its
//   next result. Reset empties the output and sets 64 rows, 16 columns and
//   an empty word; the grid and word stores are not cleared.
//   The configuration channel (i_cfg_valid / o_cfg_ready) is always ready.
// ============================================================================
module grid_word_search_unit #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 16,
    parameter int MAX_WORD = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gws_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gws_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [6:0]         i_cfg_data
);
    import gws_pkg::*;

    localparam int GDEPTH = MAX_ROWS * MAX_COLS;
    localparam int GAW    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
    localparam int WA     = $clog2(MAX_WORD);

    logic [6:0]     r_grid_rows;
    logic [4:0]     r_grid_cols;
    logic [4:0]     r_word_len;
    t_cfg           w_cfg;

    logic           w_in_acc;
    logic           w_grid_we;
    logic [GAW-1:0] w_grid_waddr;
    logic           w_word_we;
    logic [WA-1:0]  w_word_waddr;
    logic [GAW-1:0] w_grid_raddr;
    logic [7:0]     w_grid_q;
    logic [WA-1:0]  w_word_raddr;
    logic [7:0]     w_word_q;

    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;

    // Register writes: the user must send these only while the block is idle; the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= 7'd64;
            r_grid_cols <= 5'd16;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROWS: r_grid_rows <= i_cfg_data;
                CFG_COLS: r_grid_cols <= i_cfg_data[4:0];
                default:  r_grid_rows <= r_grid_rows;
            endcase
        end
    end

    // Word length advances only on the final letter of a word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_len <= '0;
        end else if (w_word_we && i_in_item.final_letter) begin
            r_word_len <= {1'b0, i_in_item.letter_index} + 5'd1;
        end
    end

    // Clamp the settings to what the stores can hold
    always_comb begin
        if (r_grid_rows == '0) begin
            w_cfg.rows = 7'd1;
        end else if (32'(r_grid_rows) > MAX_ROWS) begin
            w_cfg.rows = 7'(MAX_ROWS);
        end else begin
            w_cfg.rows = r_grid_rows;
        end
        if (r_grid_cols == '0) begin
            w_cfg.cols = 5'd1;
        end else if (32'(r_grid_cols) > MAX_COLS) begin
            w_cfg.cols = 5'(MAX_COLS);
        end else begin
            w_cfg.cols = r_grid_cols;
        end
        if (32'(r_word_len) > MAX_WORD) begin
            w_cfg.len = LEN_W'(MAX_WORD);
        end else begin
            w_cfg.len = LEN_W'(r_word_len);
        end
    end

    // Drop writes that fall outside the stores
    assign w_grid_we    = w_in_acc && i_in_item.action == ACT_GRID
                          && 32'(i_in_item.row) < MAX_ROWS && 32'(i_in_item.col) < MAX_COLS;
    assign w_grid_waddr = GAW'(32'(i_in_item.row) * MAX_COLS + 32'(i_in_item.col));
    assign w_word_we    = w_in_acc && i_in_item.action == ACT_WORD
                          && 32'(i_in_item.letter_index) < MAX_WORD;
    assign w_word_waddr = WA'(i_in_item.letter_index);

    gws_ram #(
        .W     (8),
        .DEPTH (GDEPTH),
        .AW    (GAW)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (w_grid_we),
        .i_waddr (w_grid_waddr),
        .i_wdata (i_in_item.letter),
        .i_raddr (w_grid_raddr),
        .o_rdata (w_grid_q)
    );

    gws_ram #(
        .W     (8),
        .DEPTH (MAX_WORD),
        .AW    (WA)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (w_word_we),
        .i_waddr (w_word_waddr),
        .i_wdata (i_in_item.letter),
        .i_raddr (w_word_raddr),
        .o_rdata (w_word_q)
    );

    gws_ctrl #(
        .MAX_COLS (MAX_COLS),
        .GAW      (GAW),
        .WA       (WA)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_cfg        (w_cfg),
        .o_grid_raddr (w_grid_raddr),
        .i_grid_q     (w_grid_q),
        .o_word_raddr (w_word_raddr),
        .i_word_q     (w_word_q),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

    // Writes and unused actions never take the block out of idle
    a_write_stays_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && !(i_in_valid && i_in_item.action == ACT_SEARCH) |=> o_in_ready)
        else $error("ready dropped without a search item");

    // An accepted search always takes the sequencer out of idle in the next cycle
    a_search_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && i_in_valid && i_in_item.action == ACT_SEARCH |=> !o_in_ready)
        else $error("search item accepted without leaving idle");

    // No-match and short-word results always close a search
    a_status_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != STAT_MATCH |-> o_out_item.last)
        else $error("non-match result without last flag");

endmodule
